### src/drd_pkg.sv
package drd_pkg;

    localparam int MAX_CLASSES = 256;
    localparam int MAX_ROWS    = 16384;

    localparam int VAL_W   = 24;
    localparam int SCORE_W = 23;
    localparam int CLS_W   = 8;
    localparam int ROW_W   = 14;
    localparam int COORD_W = 16;
    localparam int PIX_W   = 12;
    localparam int THR_W   = 13;
    localparam int NCLS_W  = 9;
    localparam int SCALE_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // element counter must hold the four box slots plus every class slot
    localparam int CNT_W = $clog2(MAX_CLASSES + 4);

    // doubled corner minus shifted offset, Q.13
    localparam int EDGE_W = 27;
    localparam int PROD_W = EDGE_W + SCALE_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONF_THR   = 3'd0,
        CFG_NUM_CLS    = 3'd1,
        CFG_INV_SCALE  = 3'd2,
        CFG_OFFSET_X   = 3'd3,
        CFG_OFFSET_Y   = 3'd4,
        CFG_IMG_WIDTH  = 3'd5,
        CFG_IMG_HEIGHT = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0]   conf_threshold;
        logic [NCLS_W-1:0]  num_classes;
        logic [SCALE_W-1:0] inv_scale;
        logic [COORD_W-1:0] offset_x;
        logic [COORD_W-1:0] offset_y;
        logic [PIX_W-1:0]   image_width;
        logic [PIX_W-1:0]   image_height;
    } t_cfg;

    typedef struct packed {
        logic [ROW_W-1:0]   row_index;
        logic [CLS_W-1:0]   class_id;
        logic [SCORE_W-1:0] score;
    } t_det_meta;

    // edge order: left, top, right, bottom
    typedef struct packed {
        t_det_meta                 meta;
        logic signed [EDGE_W-1:0]  x1;
        logic signed [EDGE_W-1:0]  y1;
        logic signed [EDGE_W-1:0]  x2;
        logic signed [EDGE_W-1:0]  y2;
    } t_edge_beat;

endpackage

### src/drd_cfg_regs.sv
module drd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [drd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [drd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output drd_pkg::t_cfg                  o_cfg
);
    import drd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.conf_threshold <= THR_W'(1024);
            r_cfg.num_classes    <= NCLS_W'(80);
            r_cfg.inv_scale      <= SCALE_W'(65536);
            r_cfg.offset_x       <= '0;
            r_cfg.offset_y       <= '0;
            r_cfg.image_width    <= PIX_W'(640);
            r_cfg.image_height   <= PIX_W'(640);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CONF_THR:   r_cfg.conf_threshold <= i_cfg_data[THR_W-1:0];
                CFG_NUM_CLS:    r_cfg.num_classes    <= i_cfg_data[NCLS_W-1:0];
                CFG_INV_SCALE:  r_cfg.inv_scale      <= i_cfg_data[SCALE_W-1:0];
                CFG_OFFSET_X:   r_cfg.offset_x       <= i_cfg_data[COORD_W-1:0];
                CFG_OFFSET_Y:   r_cfg.offset_y       <= i_cfg_data[COORD_W-1:0];
                CFG_IMG_WIDTH:  r_cfg.image_width    <= i_cfg_data[PIX_W-1:0];
                CFG_IMG_HEIGHT: r_cfg.image_height   <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/drd_row_track.sv
module drd_row_track (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  drd_pkg::t_cfg                     i_cfg,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [drd_pkg::VAL_W-1:0]  i_value,
    input  logic                              i_frame_end,
    output logic                              o_s1_valid,
    input  logic                              i_s1_ready,
    output drd_pkg::t_edge_beat               o_s1
);
    import drd_pkg::*;

    logic [CNT_W-1:0]          r_elem, n_elem;
    logic [ROW_W-1:0]          r_row, n_row;
    logic [SCORE_W-1:0]        r_best, n_best;
    logic [CLS_W-1:0]          r_cls, n_cls;
    logic signed [VAL_W-1:0]   r_box [4];
    logic                      r_s1_valid;
    t_edge_beat                r_s1, n_s1;

    logic                      acc;
    logic                      box_phase;
    logic                      upd;
    logic                      row_last;
    logic                      emit;
    logic [CNT_W-1:0]          n_eff;
    logic [CNT_W-1:0]          last_idx;
    logic [SCORE_W-1:0]        best_now;
    logic [CLS_W-1:0]          cls_now;
    logic signed [EDGE_W-1:0]  cx2, cy2, w_ext, h_ext, offx, offy;

    assign o_in_ready = !r_s1_valid || i_s1_ready;
    assign acc        = i_in_valid && o_in_ready;

    always_comb begin
        if (i_cfg.num_classes == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(i_cfg.num_classes) > 32'(MAX_CLASSES)) begin
            n_eff = CNT_W'(MAX_CLASSES);
        end else begin
            n_eff = CNT_W'(i_cfg.num_classes);
        end
    end

    assign last_idx  = CNT_W'(3) + n_eff;
    assign box_phase = r_elem < CNT_W'(4);
    // positive score that beats the current best; ties keep the earlier class
    assign upd       = !i_value[VAL_W-1] && (i_value[SCORE_W-1:0] > r_best);
    assign best_now  = upd ? i_value[SCORE_W-1:0] : r_best;
    assign cls_now   = upd ? CLS_W'(r_elem - CNT_W'(4)) : r_cls;
    assign row_last  = !box_phase && (r_elem >= last_idx);
    assign emit      = row_last && (best_now >= SCORE_W'(i_cfg.conf_threshold));

    assign cx2   = {{2{r_box[0][VAL_W-1]}}, r_box[0], 1'b0};
    assign cy2   = {{2{r_box[1][VAL_W-1]}}, r_box[1], 1'b0};
    assign w_ext = {{3{r_box[2][VAL_W-1]}}, r_box[2]};
    assign h_ext = {{3{r_box[3][VAL_W-1]}}, r_box[3]};
    assign offx  = {2'b00, i_cfg.offset_x, 9'd0};
    assign offy  = {2'b00, i_cfg.offset_y, 9'd0};

    always_comb begin
        n_s1.meta.row_index = r_row;
        n_s1.meta.class_id  = cls_now;
        n_s1.meta.score     = best_now;
        n_s1.x1 = cx2 - w_ext - offx;
        n_s1.y1 = cy2 - h_ext - offy;
        n_s1.x2 = cx2 + w_ext - offx;
        n_s1.y2 = cy2 + h_ext - offy;
    end

    always_comb begin
        n_elem = r_elem;
        n_row  = r_row;
        n_best = r_best;
        n_cls  = r_cls;
        if (box_phase) begin
            n_elem = r_elem + CNT_W'(1);
        end else if (row_last) begin
            n_elem = '0;
            n_best = '0;
            n_cls  = '0;
            n_row  = (r_row == ROW_W'(MAX_ROWS - 1)) ? '0 : r_row + ROW_W'(1);
        end else begin
            n_elem = r_elem + CNT_W'(1);
            n_best = best_now;
            n_cls  = cls_now;
        end
        if (i_frame_end) begin
            n_elem = '0;
            n_best = '0;
            n_cls  = '0;
            n_row  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem     <= '0;
            r_row      <= '0;
            r_best     <= '0;
            r_cls      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_elem <= n_elem;
                r_row  <= n_row;
                r_best <= n_best;
                r_cls  <= n_cls;
            end
            if (o_in_ready) begin
                r_s1_valid <= acc && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && box_phase) begin
            r_box[r_elem[1:0]] <= i_value;
        end
        if (acc && emit) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

    a_elem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elem <= CNT_W'(MAX_CLASSES + 3))
        else $error("element counter past the longest row");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_frame_end) |=> (r_elem == '0 && r_row == '0 && r_best == '0))
        else $error("frame end did not clear row state");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !i_s1_ready) |=> (r_s1_valid && $stable(r_s1)))
        else $error("stalled edge beat changed");

    a_no_emit_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && box_phase) |=> !r_s1_valid || $past(r_s1_valid))
        else $error("box element raised a detection");

endmodule

### src/drd_box_map.sv
module drd_box_map (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  drd_pkg::t_cfg                       i_cfg,
    input  logic                                i_s1_valid,
    output logic                                o_s1_ready,
    input  drd_pkg::t_edge_beat                 i_s1,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [drd_pkg::ROW_W-1:0]           o_row_index,
    output logic [drd_pkg::CLS_W-1:0]           o_class_id,
    output logic [drd_pkg::SCORE_W-1:0]         o_score,
    output logic [drd_pkg::COORD_W-1:0]         o_box_x,
    output logic [drd_pkg::COORD_W-1:0]         o_box_y,
    output logic [drd_pkg::COORD_W-1:0]         o_box_width,
    output logic [drd_pkg::COORD_W-1:0]         o_box_height
);
    import drd_pkg::*;

    function automatic logic [COORD_W-1:0] round_clamp(
        input logic signed [PROD_W-1:0] p,
        input logic [PIX_W-1:0]         limit_px
    );
        logic [PROD_W-2:0]   r;
        logic [COORD_W-1:0]  lim;
        logic [COORD_W-1:0]  q;
        r   = p[PROD_W-2:0] + (PROD_W-1)'(1 << 24);
        lim = {limit_px, 4'd0};
        if (p[PROD_W-1] || p == '0) begin
            q = '0;
        end else if (r[PROD_W-2:25] > (PROD_W-26)'(lim)) begin
            q = lim;
        end else begin
            q = r[25+COORD_W-1:25];
        end
        return q;
    endfunction

    // stage 2: products, stage 3: clamped corners, stage 4: output register
    logic                       r_s2_valid, r_s3_valid, r_out_valid;
    t_det_meta                  r_s2_meta, r_s3_meta, r_out_meta;
    logic signed [PROD_W-1:0]   r_px1, r_py1, r_px2, r_py2;
    logic [COORD_W-1:0]         r_x1, r_y1, r_x2, r_y2;
    logic [COORD_W-1:0]         r_bx, r_by, r_bw, r_bh;
    logic signed [SCALE_W:0]    scale_s;
    logic                       free_out, free3, free2;

    assign free_out   = !r_out_valid || i_out_ready;
    assign free3      = !r_s3_valid || free_out;
    assign free2      = !r_s2_valid || free3;
    assign o_s1_ready = free2;
    assign scale_s    = {1'b0, i_cfg.inv_scale};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (free2) begin
                r_s2_valid <= i_s1_valid;
            end
            if (free3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (free_out) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free2 && i_s1_valid) begin
            r_s2_meta <= i_s1.meta;
            r_px1     <= i_s1.x1 * scale_s;
            r_py1     <= i_s1.y1 * scale_s;
            r_px2     <= i_s1.x2 * scale_s;
            r_py2     <= i_s1.y2 * scale_s;
        end
        if (free3 && r_s2_valid) begin
            r_s3_meta <= r_s2_meta;
            r_x1      <= round_clamp(r_px1, i_cfg.image_width);
            r_y1      <= round_clamp(r_py1, i_cfg.image_height);
            r_x2      <= round_clamp(r_px2, i_cfg.image_width);
            r_y2      <= round_clamp(r_py2, i_cfg.image_height);
        end
        if (free_out && r_s3_valid) begin
            r_out_meta <= r_s3_meta;
            r_bx       <= r_x1;
            r_by       <= r_y1;
            r_bw       <= (r_x2 > r_x1) ? r_x2 - r_x1 : '0;
            r_bh       <= (r_y2 > r_y1) ? r_y2 - r_y1 : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_row_index  = r_out_meta.row_index;
    assign o_class_id   = r_out_meta.class_id;
    assign o_score      = r_out_meta.score;
    assign o_box_x      = r_bx;
    assign o_box_y      = r_by;
    assign o_box_width  = r_bw;
    assign o_box_height = r_bh;

endmodule

### src/detection_row_decode_top.sv
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_value, i_frame_end
// result    out        o_out_valid / i_out_ready  o_row_index .. o_box_height
// config    in         i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// One element is taken every cycle while o_in_ready is high. A detection passes
// four registers after the beat that closes its row: edge sums, multiply,
// round/clamp, then width/height subtract. Synchronous active-low reset clears
// counters, arg-max and valid flags; config returns to its defaults. A stalled
// output only holds back input once all four result stages are full.
module detection_row_decode_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [drd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [drd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [drd_pkg::VAL_W-1:0]    i_value,
    input  logic                                i_frame_end,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [drd_pkg::ROW_W-1:0]           o_row_index,
    output logic [drd_pkg::CLS_W-1:0]           o_class_id,
    output logic [drd_pkg::SCORE_W-1:0]         o_score,
    output logic [drd_pkg::COORD_W-1:0]         o_box_x,
    output logic [drd_pkg::COORD_W-1:0]         o_box_y,
    output logic [drd_pkg::COORD_W-1:0]         o_box_width,
    output logic [drd_pkg::COORD_W-1:0]         o_box_height
);
    import drd_pkg::*;

    t_cfg       cfg;
    t_edge_beat s1;
    logic       s1_valid;
    logic       s1_ready;

    drd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    drd_row_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .i_frame_end (i_frame_end),
        .o_s1_valid  (s1_valid),
        .i_s1_ready  (s1_ready),
        .o_s1        (s1)
    );

    drd_box_map u_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_s1_valid   (s1_valid),
        .o_s1_ready   (s1_ready),
        .i_s1         (s1),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_row_index  (o_row_index),
        .o_class_id   (o_class_id),
        .o_score      (o_score),
        .o_box_x      (o_box_x),
        .o_box_y      (o_box_y),
        .o_box_width  (o_box_width),
        .o_box_height (o_box_height)
    );

endmodule

### bench/drd_detection_checker.sv
`timescale 1ns / 100ps

module drd_detection_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [drd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [drd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [drd_pkg::VAL_W-1:0]    i_value,
    input  logic                                i_frame_end,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [drd_pkg::ROW_W-1:0]           i_row_index,
    input  logic [drd_pkg::CLS_W-1:0]           i_class_id,
    input  logic [drd_pkg::SCORE_W-1:0]         i_score,
    input  logic [drd_pkg::COORD_W-1:0]         i_box_x,
    input  logic [drd_pkg::COORD_W-1:0]         i_box_y,
    input  logic [drd_pkg::COORD_W-1:0]         i_box_width,
    input  logic [drd_pkg::COORD_W-1:0]         i_box_height,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import drd_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0]   row_index;
        logic [CLS_W-1:0]   class_id;
        logic [SCORE_W-1:0] score;
        logic [COORD_W-1:0] box_x;
        logic [COORD_W-1:0] box_y;
        logic [COORD_W-1:0] box_width;
        logic [COORD_W-1:0] box_height;
    } t_det;

    t_det expected_dets [$];

    t_cfg                     cfg;
    int                       elem_idx;
    int                       row_num;
    logic signed [VAL_W-1:0]  box_q [4];
    logic [SCORE_W-1:0]       best_score;
    logic [CLS_W-1:0]         best_class;

    // corner in Q.13 minus offset, times inv scale (Q.16) to 2^-29, round half up to Q12.4
    function automatic logic [COORD_W-1:0] map_corner(input longint twice_edge,
            input logic [COORD_W-1:0] offs, input logic [PIX_W-1:0] limit_px);
        longint prod, q, lim;
        prod = (twice_edge - (longint'(offs) << 9)) * longint'(cfg.inv_scale);
        lim = longint'(limit_px) << 4;
        if (prod <= 0) return '0;
        q = (prod + (longint'(1) << 24)) >>> 25;
        if (q > lim) q = lim;
        return COORD_W'(q);
    endfunction

    task automatic decode_element(input logic signed [VAL_W-1:0] v, input logic fe);
        int n_eff;
        longint cx2, cy2, w, h;
        logic [COORD_W-1:0] x1, y1, x2, y2;
        t_det det;
        n_eff = int'(cfg.num_classes);
        if (n_eff < 1) n_eff = 1;
        if (n_eff > MAX_CLASSES) n_eff = MAX_CLASSES;
        if (elem_idx < 4) begin
            box_q[elem_idx] = v;
            elem_idx++;
        end else begin
            // strictly above zero and strictly above the current best: first max wins
            if (v > 0 && longint'(v) > longint'(best_score)) begin
                best_score = v[SCORE_W-1:0];
                best_class = CLS_W'(elem_idx - 4);
            end
            if (elem_idx >= 3 + n_eff) begin
                if (best_score >= cfg.conf_threshold) begin
                    cx2 = 2 * longint'(box_q[0]);
                    cy2 = 2 * longint'(box_q[1]);
                    w   = longint'(box_q[2]);
                    h   = longint'(box_q[3]);
                    x1 = map_corner(cx2 - w, cfg.offset_x, cfg.image_width);
                    y1 = map_corner(cy2 - h, cfg.offset_y, cfg.image_height);
                    x2 = map_corner(cx2 + w, cfg.offset_x, cfg.image_width);
                    y2 = map_corner(cy2 + h, cfg.offset_y, cfg.image_height);
                    det.row_index  = ROW_W'(row_num);
                    det.class_id   = best_class;
                    det.score      = best_score;
                    det.box_x      = x1;
                    det.box_y      = y1;
                    det.box_width  = (x2 > x1) ? x2 - x1 : '0;
                    det.box_height = (y2 > y1) ? y2 - y1 : '0;
                    expected_dets.insert(expected_dets.size(), det);
                end
                row_num = (row_num + 1 >= MAX_ROWS) ? 0 : row_num + 1;
                elem_idx   = 0;
                best_score = '0;
                best_class = '0;
            end else begin
                elem_idx++;
            end
        end
        if (fe) begin
            row_num    = 0;
            elem_idx   = 0;
            best_score = '0;
            best_class = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_det want, got;
        if (!i_rst_n) begin
            cfg.conf_threshold = 13'd1024;
            cfg.num_classes    = 9'd80;
            cfg.inv_scale      = 24'd65536;
            cfg.offset_x       = '0;
            cfg.offset_y       = '0;
            cfg.image_width    = 12'd640;
            cfg.image_height   = 12'd640;
            elem_idx   = 0;
            row_num    = 0;
            best_score = '0;
            best_class = '0;
            for (int k = 0; k < 4; k++) box_q[k] = '0;
            expected_dets.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_row_index, i_class_id, i_score, i_box_x, i_box_y,
                       i_box_width, i_box_height};
                if (expected_dets.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("exp none, got row %0d class %0d score %0d",
                                 got.row_index, got.class_id, got.score);
                    o_fail_count++;
                end else begin
                    want = expected_dets.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10) begin
                            $display("detection mismatch at %0t", $realtime);
                            $display("  exp row %0d cls %0d score %0d box %0d %0d %0d %0d",
                                     want.row_index, want.class_id, want.score, want.box_x,
                                     want.box_y, want.box_width, want.box_height);
                            $display("  got row %0d cls %0d score %0d box %0d %0d %0d %0d",
                                     got.row_index, got.class_id, got.score, got.box_x,
                                     got.box_y, got.box_width, got.box_height);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) decode_element(i_value, i_frame_end);
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CONF_THR:   cfg.conf_threshold = i_cfg_data[THR_W-1:0];
                    CFG_NUM_CLS:    cfg.num_classes    = i_cfg_data[NCLS_W-1:0];
                    CFG_INV_SCALE:  cfg.inv_scale      = i_cfg_data[SCALE_W-1:0];
                    CFG_OFFSET_X:   cfg.offset_x       = i_cfg_data[COORD_W-1:0];
                    CFG_OFFSET_Y:   cfg.offset_y       = i_cfg_data[COORD_W-1:0];
                    CFG_IMG_WIDTH:  cfg.image_width    = i_cfg_data[PIX_W-1:0];
                    CFG_IMG_HEIGHT: cfg.image_height   = i_cfg_data[PIX_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_dets.size();
    end

endmodule

### bench/detection_row_decode_top_tb.sv
`timescale 1ns / 100ps

module detection_row_decode_top_tb;
    import drd_pkg::*;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 24'h7FFFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 24'h800000;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [VAL_W-1:0]  in_value;
    logic                     in_frame_end;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [ROW_W-1:0]         det_row;
    logic [CLS_W-1:0]         det_class;
    logic [SCORE_W-1:0]       det_score;
    logic [COORD_W-1:0]       det_x;
    logic [COORD_W-1:0]       det_y;
    logic [COORD_W-1:0]       det_w;
    logic [COORD_W-1:0]       det_h;

    int fail_count;
    int pending;
    logic out_beat = 1'b0;
    int stall = 0;

    bit tx_idle;
    bit rx_stall_on = 1'b1;
    int row_pos;
    int ncls_eff;
    int cur_thr;
    logic signed [VAL_W-1:0] last_score;

    detection_row_decode_top uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_value      (in_value),
        .i_frame_end  (in_frame_end),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_row_index  (det_row),
        .o_class_id   (det_class),
        .o_score      (det_score),
        .o_box_x      (det_x),
        .o_box_y      (det_y),
        .o_box_width  (det_w),
        .o_box_height (det_h)
    );

    drd_detection_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_value      (in_value),
        .i_frame_end  (in_frame_end),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_row_index  (det_row),
        .i_class_id   (det_class),
        .i_score      (det_score),
        .i_box_x      (det_x),
        .i_box_y      (det_y),
        .i_box_width  (det_w),
        .i_box_height (det_h),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(1_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stall after every accepted beat while rx_stall_on is set
    always @(posedge clk) begin
        out_beat <= out_valid && out_ready;
    end

    always @(negedge clk) begin
        if (out_beat) stall = rx_stall_on ? $urandom_range(0, 10) : 0;
        if (stall > 0) begin
            out_ready <= 1'b0;
            stall--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // entered at a falling edge; valid stays high into the next beat when there is no gap
    task automatic send_element(input logic signed [VAL_W-1:0] v, input logic fe);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        in_value     <= v;
        in_frame_end <= fe;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (row_pos >= 4 && row_pos >= 3 + ncls_eff) row_pos = 0;
        else row_pos++;
        if (fe) row_pos = 0;
    endtask

    task automatic drain_dets();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic cfg_put(input t_cfg_idx idx, input int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        @(negedge clk);
    endtask

    task automatic write_all(input int thr, input int ncls, input int scale,
                             input int ox, input int oy, input int iw, input int ih);
        cfg_put(CFG_CONF_THR, thr);
        cfg_put(CFG_NUM_CLS, ncls);
        cfg_put(CFG_INV_SCALE, scale);
        cfg_put(CFG_OFFSET_X, ox);
        cfg_put(CFG_OFFSET_Y, oy);
        cfg_put(CFG_IMG_WIDTH, iw);
        cfg_put(CFG_IMG_HEIGHT, ih);
        cfg_we <= 1'b0;
        cur_thr  = thr;
        ncls_eff = (ncls < 1) ? 1 : ((ncls > MAX_CLASSES) ? MAX_CLASSES : ncls);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_box(input int slot);
        if ($urandom_range(0, 7) == 0) return VAL_W'($urandom());
        if (slot < 2) return VAL_W'(int'($urandom_range(0, 800 << 12)) - (50 << 12));
        return VAL_W'($urandom_range(0, 700 << 12));
    endfunction

    initial begin
        logic signed [VAL_W-1:0] sc;
        logic fe;
        bit closing;
        int rand_items, len, k;
        int thr, ncls, scale, ox, oy, iw, ih;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_CONF_THR;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_value     = '0;
        in_frame_end = 1'b0;
        tx_idle      = 1'b1;
        row_pos      = 0;
        ncls_eff     = 80;
        cur_thr      = 1024;
        last_score   = 24'sd1;
        rand_items   = 0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // value extremes: clamp high and low, tie on the max score, inverted box
        write_all(1024, 3, 65536, 0, 0, 640, 640);
        send_element(VAL_MAX, 1'b0);
        send_element(VAL_MIN, 1'b0);
        send_element(VAL_MIN, 1'b0);
        send_element(VAL_MAX, 1'b0);
        send_element(VAL_MAX, 1'b0);
        send_element(VAL_MAX, 1'b0);
        send_element(VAL_MIN, 1'b0);
        // score exactly at threshold, frame end on the closing element
        send_element(24'sd320 <<< 12, 1'b0);
        send_element(24'sd240 <<< 12, 1'b0);
        send_element(24'sd100 <<< 12, 1'b0);
        send_element(24'sd80 <<< 12, 1'b0);
        send_element(24'sd1023, 1'b0);
        send_element(24'sd1024, 1'b0);
        send_element(24'sd1024, 1'b1);
        // frame end inside the box fields drops the partial row
        send_element(24'sd10 <<< 12, 1'b0);
        send_element(24'sd20 <<< 12, 1'b0);
        send_element(24'sd30 <<< 12, 1'b1);
        // partial row left open, then class count cut below its position
        send_element(24'sd200 <<< 12, 1'b0);
        send_element(24'sd150 <<< 12, 1'b0);
        send_element(24'sd60 <<< 12, 1'b0);
        send_element(24'sd40 <<< 12, 1'b0);
        send_element(24'sd5000, 1'b0);
        drain_dets();
        write_all(0, 0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 4095, 1);
        send_element(24'sd0, 1'b0);
        // no positive score with zero threshold
        send_element(24'sd600 <<< 12, 1'b0);
        send_element(24'sd500 <<< 12, 1'b0);
        send_element(24'sd100 <<< 12, 1'b0);
        send_element(24'sd100 <<< 12, 1'b0);
        send_element(-24'sd1, 1'b0);
        drain_dets();

        while (rand_items < 1100) begin
            drain_dets();
            case ($urandom_range(0, 5))
                0:       thr = 0;
                1:       thr = 4096;
                default: thr = $urandom_range(0, 4096);
            endcase
            k = $urandom_range(0, 29);
            if (k == 0) ncls = 256;
            else if (k == 1) ncls = $urandom_range(257, 511);
            else if (k == 2) ncls = 0;
            else if (k < 6) ncls = $urandom_range(9, 80);
            else ncls = $urandom_range(1, 8);
            case ($urandom_range(0, 5))
                0:       scale = 0;
                1:       scale = 24'hFFFFFF;
                2:       scale = $urandom_range(0, 24'hFFFFFF);
                default: scale = $urandom_range(32768, 131072);
            endcase
            case ($urandom_range(0, 5))
                0:       ox = 0;
                1:       ox = 16'hFFFF;
                2:       ox = $urandom_range(0, 16'hFFFF);
                default: ox = $urandom_range(0, 2000);
            endcase
            case ($urandom_range(0, 5))
                0:       oy = 0;
                1:       oy = 16'hFFFF;
                2:       oy = $urandom_range(0, 16'hFFFF);
                default: oy = $urandom_range(0, 2000);
            endcase
            case ($urandom_range(0, 5))
                0:       iw = 1;
                1:       iw = 4095;
                2:       iw = 640;
                default: iw = $urandom_range(1, 4095);
            endcase
            case ($urandom_range(0, 5))
                0:       ih = 1;
                1:       ih = 4095;
                2:       ih = 640;
                default: ih = $urandom_range(1, 4095);
            endcase
            write_all(thr, ncls, scale, ox, oy, iw, ih);
            tx_idle     = $urandom_range(0, 3) != 0;
            rx_stall_on = $urandom_range(0, 3) != 0;
            len = (ncls > 80) ? 300 : $urandom_range(20, 120);
            if (len > 1100 - rand_items) len = 1100 - rand_items;
            for (int i = 0; i < len; i++) begin
                closing = (row_pos >= 4) && (row_pos >= 3 + ncls_eff);
                if (row_pos < 4) begin
                    sc = pick_box(row_pos);
                end else begin
                    case ($urandom_range(0, 15))
                        0, 1, 2: sc = {1'b1, SCORE_W'($urandom())};
                        3:       sc = -VAL_W'($urandom_range(0, 16));
                        4, 5:    sc = last_score;
                        6:       sc = {1'b0, SCORE_W'($urandom())};
                        default: sc = VAL_W'($urandom_range(0, 2 * cur_thr + 16));
                    endcase
                    if (sc > 0) last_score = sc;
                end
                fe = closing ? ($urandom_range(0, 5) == 0) : ($urandom_range(0, 149) == 0);
                send_element(sc, fe);
                rand_items++;
            end
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
src/drd_pkg.sv
src/drd_cfg_regs.sv
src/drd_row_track.sv
src/drd_box_map.sv
src/detection_row_decode_top.sv
bench/drd_detection_checker.sv
bench/detection_row_decode_top_tb.sv
